// File: hw/rtl/harq_pkg.sv
// harq_pkg: shared types, constants and slot-time helpers for the HARQ process table.
// No dependencies; imported by harq_front, harq_engine and harq_process_table.
`default_nettype none
package harq_pkg;

    localparam int NUM_PROC   = 8;
    localparam int PID_W      = 3;
    localparam int NUM_BLK    = 2;
    localparam int ENT_W      = PID_W + 1;
    localparam int NUM_ENT    = NUM_PROC * NUM_BLK;
    localparam int TIME_WRAP  = 10240;
    localparam int TIME_W     = 14;
    localparam int ACK_DELAY  = 4;
    localparam int RETX_DELAY = 4;
    localparam int STALE_AGE  = 100;
    localparam int IN_W       = 48;
    localparam int OUT_W      = 40;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 4;

    localparam logic [TIME_W:0]   WRAP_X    = (TIME_W+1)'(TIME_WRAP);
    localparam logic [TIME_W-1:0] HALF_WRAP = TIME_W'(TIME_WRAP / 2);

    typedef logic [2:0] cmd_t;
    localparam cmd_t CMD_NEW_TX       = 3'd0;
    localparam cmd_t CMD_RETX         = 3'd1;
    localparam cmd_t CMD_ACK          = 3'd2;
    localparam cmd_t CMD_FIND_EMPTY   = 3'd3;
    localparam cmd_t CMD_FIND_PENDING = 3'd4;
    localparam cmd_t CMD_TICK         = 3'd5;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NO_MATCH = 2'd1;
    localparam status_t ST_INACTIVE = 2'd2;

    typedef logic [1:0] ack_t;
    localparam ack_t ACK_NONE = 2'd0;
    localparam ack_t ACK_YES  = 2'd1;
    localparam ack_t ACK_NO   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_RETX = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ASYNC    = CFG_IDX_W'(1);

    localparam logic [3:0] FOUND_NONE = 4'(NUM_PROC);

    typedef enum logic {ENG_IDLE, ENG_RUN} eng_state_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [PID_W-1:0]   pid;
        logic               blk;
        logic [TIME_W-1:0]  slot;
        logic               ack;
        logic [4:0]         mcs;
        logic [19:0]        tbs;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [3:0]         found;
        logic signed [5:0]  scheme;
        logic signed [20:0] size;
        logic               ndi;
        logic               disc;
    } result_t;

    // queue head as seen by the engine
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    function automatic logic [TIME_W-1:0] t_add(input logic [TIME_W-1:0] t,
                                                input logic [TIME_W-1:0] d);
        logic [TIME_W:0] s;
        s = {1'b0, t} + {1'b0, d};
        if (s >= WRAP_X) s = s - WRAP_X;
        return s[TIME_W-1:0];
    endfunction

    // (a - b) mod TIME_WRAP, both operands already reduced
    function automatic logic [TIME_W-1:0] t_dist(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
        logic [TIME_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (a < b) d = d + WRAP_X;
        return d[TIME_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/harq_front.sv
// harq_front: accepts command transfers, unpacks and reduces the slot, and
// buffers them in a two-entry queue. Depends on harq_pkg.
`default_nettype none
module harq_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // command, process_id, block_index, slot_time, ack_bit, coding_scheme, block_size
    input  wire logic [harq_pkg::IN_W-1:0] s_tdata,
    output harq_pkg::queue_head_t        q_head,
    input  wire logic                    q_pop
);
    import harq_pkg::*;

    item_t           q_mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    item_t           in_item;
    logic [TIME_W-1:0] raw_slot;
    logic            push;

    assign raw_slot = s_tdata[20:7];

    always_comb begin
        in_item.cmd  = s_tdata[2:0];
        in_item.pid  = s_tdata[5:3];
        in_item.blk  = s_tdata[6];
        in_item.slot = (raw_slot >= WRAP_X[TIME_W-1:0]) ? raw_slot - WRAP_X[TIME_W-1:0]
                                                        : raw_slot;
        in_item.ack  = s_tdata[21];
        in_item.mcs  = s_tdata[26:22];
        in_item.tbs  = s_tdata[46:27];
    end

    assign s_tready     = (count_reg != 2'd2);
    assign push         = s_tvalid && s_tready;
    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.item  = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) q_mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule
`default_nettype wire

// File: hw/rtl/harq_engine.sv
// harq_engine: process table, configuration registers and the sequencer that
// executes one command at a time, scanning processes one per cycle. Depends on harq_pkg.
`default_nettype none
module harq_engine (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire harq_pkg::queue_head_t         q_head,
    output logic                               q_pop,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [harq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [harq_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // status, found_process, stored_scheme, stored_size, new_data_flag, discarded
    output logic [harq_pkg::OUT_W-1:0]         m_tdata
);
    import harq_pkg::*;

    logic               active_reg [NUM_ENT];
    ack_t               ack_reg    [NUM_ENT];
    logic [3:0]         retx_reg   [NUM_ENT];
    logic               ndi_reg    [NUM_ENT];
    logic signed [5:0]  scheme_reg [NUM_ENT];
    logic signed [20:0] size_reg   [NUM_ENT];
    logic [TIME_W-1:0]  ptime_reg  [NUM_PROC];

    logic [3:0]         retx_limit_reg;
    logic               async_reg;

    eng_state_t         state_reg, state_next;
    item_t              item_reg;
    logic [PID_W-1:0]   cnt_reg;
    logic               hit_reg;
    logic [TIME_W-1:0]  best_reg;
    logic [PID_W-1:0]   best_p_reg;
    logic               m_valid_reg;
    result_t            m_res_reg;

    logic               out_free, finish, last;
    logic [PID_W-1:0]   p;
    logic [ENT_W-1:0]   bi, b0, b1;
    logic [TIME_W-1:0]  tq, age, due_d, stale_d;
    logic               ack_hit, empty_p, pend_p, stale, cand, disc;
    result_t            res;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign q_pop     = (state_reg == ENG_IDLE) && q_head.valid && out_free;
    assign last      = (cnt_reg == PID_W'(NUM_PROC - 1));

    // process under test this cycle
    always_comb begin
        case (item_reg.cmd)
            CMD_NEW_TX, CMD_RETX: p = item_reg.pid;
            CMD_FIND_EMPTY, CMD_FIND_PENDING:
                p = async_reg ? cnt_reg : item_reg.slot[PID_W-1:0]; // slot mod NUM_PROC
            default: p = cnt_reg;
        endcase
    end

    assign bi = {p, item_reg.blk};
    assign b0 = {p, 1'b0};
    assign b1 = {p, 1'b1};
    assign tq = ptime_reg[p];

    always_comb begin
        ack_hit = (t_add(tq, TIME_W'(ACK_DELAY)) == item_reg.slot);
        empty_p = !active_reg[b0] && !active_reg[b1];
        due_d   = t_dist(item_reg.slot, t_add(tq, TIME_W'(ACK_DELAY + RETX_DELAY)));
        pend_p  = (due_d <= HALF_WRAP) &&
                  ((active_reg[b0] && ack_reg[b0] == ACK_NO) ||
                   (active_reg[b1] && ack_reg[b1] == ACK_NO));
        age     = t_dist(item_reg.slot, tq);
        cand    = pend_p && (!hit_reg || age > best_reg);
        stale_d = t_dist(t_add(item_reg.slot, TIME_W'(RETX_DELAY)),
                         t_add(tq, TIME_W'(STALE_AGE)));
        stale   = !empty_p && (stale_d != '0) && (stale_d <= HALF_WRAP);
        disc    = !item_reg.ack &&
                  ({1'b0, retx_reg[bi]} + 5'd1 >= {1'b0, retx_limit_reg});
    end

    always_comb begin
        res.status = ST_NO_MATCH;
        res.found  = FOUND_NONE;
        res.scheme = -6'sd1;
        res.size   = -21'sd1;
        res.ndi    = 1'b0;
        res.disc   = 1'b0;
        finish     = 1'b1;
        case (item_reg.cmd)
            CMD_NEW_TX: begin
                res.status = ST_OK;
                res.found  = 4'(p);
                res.ndi    = ~ndi_reg[bi];
            end
            CMD_RETX: begin
                res.status = ST_OK;
                res.found  = 4'(p);
                res.scheme = scheme_reg[bi];
                res.size   = size_reg[bi];
                res.ndi    = ndi_reg[bi];
            end
            CMD_ACK: begin
                finish = ack_hit || last;
                if (ack_hit) begin
                    res.found = 4'(p);
                    res.ndi   = ndi_reg[bi];
                    if (!active_reg[bi]) begin
                        res.status = ST_INACTIVE;
                    end else begin
                        res.status = ST_OK;
                        res.size   = size_reg[bi];
                        res.disc   = disc;
                    end
                end
            end
            CMD_FIND_EMPTY: begin
                if (async_reg) finish = empty_p || last;
                if (empty_p) begin
                    res.status = ST_OK;
                    res.found  = 4'(p);
                end
            end
            CMD_FIND_PENDING: begin
                if (!async_reg) begin
                    if (pend_p) begin
                        res.status = ST_OK;
                        res.found  = 4'(p);
                    end
                end else begin
                    finish = last;
                    if (cand) begin
                        res.status = ST_OK;
                        res.found  = 4'(p);
                    end else if (hit_reg) begin
                        res.status = ST_OK;
                        res.found  = 4'(best_p_reg);
                    end
                end
            end
            CMD_TICK: begin
                finish     = last;
                res.status = ST_OK;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ENG_IDLE: if (q_pop) state_next = ENG_RUN;
            ENG_RUN:  if (finish) state_next = ENG_IDLE;
            default:  state_next = ENG_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ENG_IDLE;
            m_valid_reg    <= 1'b0;
            retx_limit_reg <= 4'd4;
            async_reg      <= 1'b0;
            cnt_reg        <= '0;
            hit_reg        <= 1'b0;
            for (int i = 0; i < NUM_ENT; i++) begin
                active_reg[i] <= 1'b0;
                ack_reg[i]    <= ACK_NONE;
                retx_reg[i]   <= 4'd0;
                ndi_reg[i]    <= 1'b0;
                scheme_reg[i] <= -6'sd1;
                size_reg[i]   <= -21'sd1;
            end
            for (int i = 0; i < NUM_PROC; i++) ptime_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                if (cfg_index == REG_MAX_RETX) retx_limit_reg <= cfg_data;
                else if (cfg_index == REG_ASYNC) async_reg <= cfg_data[0];
            end
            if (state_reg == ENG_RUN && finish) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;

            if (q_pop) begin
                item_reg <= q_head.item;
                cnt_reg  <= '0;
                hit_reg  <= 1'b0;
                // limit zero: tick frees everything before the stale scan
                if (q_head.item.cmd == CMD_TICK && retx_limit_reg == 4'd0)
                    for (int i = 0; i < NUM_ENT; i++) active_reg[i] <= 1'b0;
            end

            if (state_reg == ENG_RUN) begin
                cnt_reg <= cnt_reg + PID_W'(1);
                if (cand) begin
                    hit_reg    <= 1'b1;
                    best_reg   <= age;
                    best_p_reg <= p;
                end
                if (finish) m_res_reg <= res;
                case (item_reg.cmd)
                    CMD_NEW_TX: begin
                        active_reg[bi] <= 1'b1;
                        ack_reg[bi]    <= ACK_NONE;
                        retx_reg[bi]   <= 4'd0;
                        ndi_reg[bi]    <= ~ndi_reg[bi];
                        scheme_reg[bi] <= {1'b0, item_reg.mcs};
                        size_reg[bi]   <= {1'b0, item_reg.tbs};
                        ptime_reg[p]   <= item_reg.slot;
                    end
                    CMD_RETX: begin
                        ack_reg[bi]  <= ACK_NO;
                        ptime_reg[p] <= item_reg.slot;
                        if (retx_reg[bi] != 4'hF) retx_reg[bi] <= retx_reg[bi] + 4'd1;
                    end
                    CMD_ACK: begin
                        if (ack_hit && active_reg[bi]) begin
                            ack_reg[bi] <= item_reg.ack ? ACK_YES : ACK_NO;
                            if (item_reg.ack || disc) active_reg[bi] <= 1'b0;
                        end
                    end
                    CMD_TICK: begin
                        if (stale) begin
                            for (int b = 0; b < NUM_BLK; b++) begin
                                active_reg[{p, 1'(b)}] <= 1'b0;
                                ack_reg[{p, 1'(b)}]    <= ACK_NONE;
                                retx_reg[{p, 1'(b)}]   <= 4'd0;
                                scheme_reg[{p, 1'(b)}] <= -6'sd1;
                                size_reg[{p, 1'(b)}]   <= -21'sd1;
                            end
                            ptime_reg[p] <= '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_res_reg.disc, m_res_reg.ndi, m_res_reg.size,
                       m_res_reg.scheme, m_res_reg.found, m_res_reg.status};

endmodule
`default_nettype wire

// File: hw/rtl/harq_process_table.sv
// harq_process_table: top level; front-end queue feeding the table engine.
// Depends on harq_pkg, harq_front and harq_engine.
//
// Downlink HARQ process table (8 processes x 2 transport blocks). Every command
// transfer yields exactly one result transfer. new_tx, retx, unknown commands and
// synchronous find commands need no scan; ack and asynchronous find_empty scan
// one process per cycle from process 0, stopping at the first match, while
// asynchronous find_pending and tick scan all processes. The result is registered
// when the engine finishes, and the engine passes through idle between commands,
// so it takes no new command before it is done with the last. A two-entry input
// queue accepts commands while the engine is busy, and the output register holds a
// result until it is taken; a new command starts only once the previous result is
// taken or being taken.
// Configuration writes (index 0: max_retransmissions, index 1: async_mode) are
// always ready and must be issued only while the block is idle.
`default_nettype none
module harq_process_table (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [2:0] command, [5:3] process_id, [6] block_index, [20:7] slot_time,
    // [21] ack_bit, [26:22] coding_scheme, [46:27] block_size, [47] zero
    input  wire logic [harq_pkg::IN_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [1:0] status, [5:2] found_process, [11:6] stored_scheme, [32:12] stored_size,
    // [33] new_data_flag, [34] discarded, [39:35] zero
    output logic [harq_pkg::OUT_W-1:0]           m_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [harq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [harq_pkg::CFG_DATA_W-1:0] cfg_data
);
    import harq_pkg::*;

    queue_head_t q_head;
    logic        q_pop;

    harq_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    harq_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

// File: tb/sv/harq_checker.sv
// harq_checker: watches the command, result and config channels of harq_process_table,
// predicts each result from its own copy of the table and compares field by field.
// Depends on harq_pkg.
`default_nettype none
module harq_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [harq_pkg::IN_W-1:0]       s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [harq_pkg::OUT_W-1:0]      m_tdata,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [harq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [harq_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                   err_count,
    output int                                   pending_count
);
    import harq_pkg::*;

    logic               blk_act [NUM_PROC][NUM_BLK];
    ack_t               blk_ack [NUM_PROC][NUM_BLK];
    logic [3:0]         blk_retx[NUM_PROC][NUM_BLK];
    logic               blk_ndi [NUM_PROC][NUM_BLK];
    logic signed [5:0]  blk_mcs [NUM_PROC][NUM_BLK];
    logic signed [20:0] blk_tbs [NUM_PROC][NUM_BLK];
    int                 proc_slot[NUM_PROC];
    logic [3:0]         retx_limit;
    logic               async_on;

    result_t            expected_results[$];

    function automatic int slot_diff(int a, int b);
        int d;
        d = (a + TIME_WRAP - b) % TIME_WRAP;
        if (d > TIME_WRAP / 2) return d - TIME_WRAP;
        return d;
    endfunction

    function automatic logic proc_is_empty(int p);
        for (int b = 0; b < NUM_BLK; b++)
            if (blk_act[p][b]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic proc_is_pending(int p, int t);
        if (slot_diff(t, (proc_slot[p] + ACK_DELAY + RETX_DELAY) % TIME_WRAP) < 0)
            return 1'b0;
        for (int b = 0; b < NUM_BLK; b++)
            if (blk_act[p][b] && blk_ack[p][b] == ACK_NO) return 1'b1;
        return 1'b0;
    endfunction

    task automatic clear_blk(int p, int b);
        blk_act[p][b]  = 1'b0;
        blk_ack[p][b]  = ACK_NONE;
        blk_retx[p][b] = '0;
        blk_mcs[p][b]  = -6'sd1;
        blk_tbs[p][b]  = -21'sd1;
    endtask

    task automatic reset_table();
        for (int p = 0; p < NUM_PROC; p++) begin
            for (int b = 0; b < NUM_BLK; b++) begin
                clear_blk(p, b);
                blk_ndi[p][b] = 1'b0;
            end
            proc_slot[p] = 0;
        end
        retx_limit = 4'd4;
        async_on = 1'b0;
    endtask

    // applies one command to the table and returns the result it yields
    task automatic apply_command(input logic [IN_W-1:0] d, output result_t r);
        cmd_t       cmd;
        int         pid, blk, t, best, age, now;
        logic       ack, hit;
        logic [4:0] mcs;
        logic [19:0] tbs;
        cmd = d[2:0];
        pid = int'(d[5:3]);
        blk = int'(d[6]);
        t   = int'(d[20:7]) % TIME_WRAP;
        ack = d[21];
        mcs = d[26:22];
        tbs = d[46:27];
        r.status = ST_OK;
        r.found  = FOUND_NONE;
        r.scheme = -6'sd1;
        r.size   = -21'sd1;
        r.ndi    = 1'b0;
        r.disc   = 1'b0;
        case (cmd)
            CMD_NEW_TX: begin
                clear_blk(pid, blk);
                blk_ndi[pid][blk] = ~blk_ndi[pid][blk];
                proc_slot[pid] = t;
                blk_mcs[pid][blk] = $signed({1'b0, mcs});
                blk_tbs[pid][blk] = $signed({1'b0, tbs});
                blk_act[pid][blk] = 1'b1;
                r.found = pid[3:0];
                r.ndi = blk_ndi[pid][blk];
            end
            CMD_RETX: begin
                blk_ack[pid][blk] = ACK_NO;
                proc_slot[pid] = t;
                if (blk_retx[pid][blk] < 4'd15) blk_retx[pid][blk]++;
                r.found  = pid[3:0];
                r.scheme = blk_mcs[pid][blk];
                r.size   = blk_tbs[pid][blk];
                r.ndi    = blk_ndi[pid][blk];
            end
            CMD_ACK: begin
                r.status = ST_NO_MATCH;
                hit = 1'b0;
                for (int p = 0; p < NUM_PROC; p++) begin
                    if (!hit && (proc_slot[p] + ACK_DELAY) % TIME_WRAP == t) begin
                        hit = 1'b1;
                        r.found = p[3:0];
                        if (!blk_act[p][blk]) begin
                            r.status = ST_INACTIVE;
                        end else begin
                            r.status = ST_OK;
                            blk_ack[p][blk] = ack ? ACK_YES : ACK_NO;
                            if (!ack && int'(blk_retx[p][blk]) + 1 >= int'(retx_limit)) begin
                                blk_act[p][blk] = 1'b0;
                                r.disc = 1'b1;
                            end else if (ack) begin
                                blk_act[p][blk] = 1'b0;
                            end
                            r.size = blk_tbs[p][blk];
                        end
                        r.ndi = blk_ndi[p][blk];
                    end
                end
            end
            CMD_FIND_EMPTY, CMD_FIND_PENDING: begin
                r.status = ST_NO_MATCH;
                if (!async_on) begin
                    if (cmd == CMD_FIND_EMPTY ? proc_is_empty(t % NUM_PROC)
                                              : proc_is_pending(t % NUM_PROC, t)) begin
                        r.found  = 4'(t % NUM_PROC);
                        r.status = ST_OK;
                    end
                end else if (cmd == CMD_FIND_EMPTY) begin
                    for (int p = NUM_PROC - 1; p >= 0; p--)
                        if (proc_is_empty(p)) begin
                            r.found  = p[3:0];
                            r.status = ST_OK;
                        end
                end else begin
                    best = 0;
                    for (int p = 0; p < NUM_PROC; p++)
                        if (proc_is_pending(p, t)) begin
                            age = (t + TIME_WRAP - proc_slot[p]) % TIME_WRAP;
                            if (r.status != ST_OK || age > best) begin
                                best     = age;
                                r.found  = p[3:0];
                                r.status = ST_OK;
                            end
                        end
                end
            end
            CMD_TICK: begin
                now = (t + RETX_DELAY) % TIME_WRAP;
                if (retx_limit == 4'd0)
                    for (int p = 0; p < NUM_PROC; p++)
                        for (int b = 0; b < NUM_BLK; b++) blk_act[p][b] = 1'b0;
                for (int p = 0; p < NUM_PROC; p++)
                    if (!proc_is_empty(p) &&
                        slot_diff(now, (proc_slot[p] + STALE_AGE) % TIME_WRAP) > 0) begin
                        for (int b = 0; b < NUM_BLK; b++) clear_blk(p, b);
                        proc_slot[p] = 0;
                    end
            end
            default: r.status = ST_NO_MATCH;
        endcase
    endtask

    always @(posedge aclk) begin
        result_t exp_r, got;
        if (!aresetn) begin
            reset_table();
            expected_results.delete();
            err_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[1:0];
                got.found  = m_tdata[5:2];
                got.scheme = m_tdata[11:6];
                got.size   = m_tdata[32:12];
                got.ndi    = m_tdata[33];
                got.disc   = m_tdata[34];
                if (expected_results.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    err_count <= err_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got != exp_r) err_count <= err_count + 1;
                    if (got.status != exp_r.status)
                        $error("status: expected %0d, got %0d", exp_r.status, got.status);
                    if (got.found != exp_r.found)
                        $error("found_process: expected %0d, got %0d", exp_r.found, got.found);
                    if (got.scheme != exp_r.scheme)
                        $error("stored_scheme: expected %0d, got %0d", exp_r.scheme, got.scheme);
                    if (got.size != exp_r.size)
                        $error("stored_size: expected %0d, got %0d", exp_r.size, got.size);
                    if (got.ndi != exp_r.ndi)
                        $error("new_data_flag: expected %0d, got %0d", exp_r.ndi, got.ndi);
                    if (got.disc != exp_r.disc)
                        $error("discarded: expected %0d, got %0d", exp_r.disc, got.disc);
                end
            end
            if (s_tvalid && s_tready) begin
                apply_command(s_tdata, exp_r);
                expected_results.push_back(exp_r);
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_MAX_RETX) retx_limit = cfg_data;
                else if (cfg_index == REG_ASYNC) async_on = cfg_data[0];
            end
        end
        pending_count <= expected_results.size();
    end
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// tb_top: drives harq_process_table with directed and random commands in several
// throttling phases and reports the verdict; checking lives in harq_checker.
`default_nettype none
module tb_top;
    import harq_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0, s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid, m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic cfg_valid = 1'b0, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int err_count, pending_count;
    int send_idle_pct = 0, recv_stall_pct = 0;
    int idle_cycles = 0;
    int cur_slot = 0;
    int last_slot[NUM_PROC];

    always #4 aclk = ~aclk;

    harq_process_table u_dut (.*);

    harq_checker u_chk (.*);

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog: cycles without a command or result transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_cmd(cmd_t cmd, int pid, int blk, int slot, int ack, int mcs, int tbs);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata = {1'b0, 20'(tbs), 5'(mcs), 1'(ack), 14'(slot), 1'(blk), 3'(pid), cmd};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (cmd == CMD_NEW_TX || cmd == CMD_RETX) last_slot[pid] = slot % TIME_WRAP;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(val);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_cmd();
        int r, pid;
        r = $urandom_range(99);
        pid = $urandom_range(NUM_PROC - 1);
        cur_slot = (cur_slot + $urandom_range(3)) % TIME_WRAP;
        if (r < 25)
            send_cmd(CMD_NEW_TX, pid, $urandom_range(1), cur_slot, $urandom_range(1),
                     $urandom_range(31), $urandom_range(20'hFFFFF));
        else if (r < 40)
            send_cmd(CMD_RETX, pid, $urandom_range(1), cur_slot, $urandom_range(1),
                     $urandom_range(31), $urandom_range(20'hFFFFF));
        else if (r < 62)
            send_cmd(CMD_ACK, $urandom_range(7), $urandom_range(1),
                     ($urandom_range(99) < 85) ? (last_slot[pid] + ACK_DELAY) % TIME_WRAP
                                               : $urandom_range(16383),
                     $urandom_range(1), $urandom_range(31), $urandom_range(20'hFFFFF));
        else if (r < 72)
            send_cmd(CMD_FIND_EMPTY, $urandom_range(7), $urandom_range(1), cur_slot,
                     $urandom_range(1), $urandom_range(31), $urandom_range(20'hFFFFF));
        else if (r < 85)
            send_cmd(CMD_FIND_PENDING, $urandom_range(7), $urandom_range(1),
                     (cur_slot + $urandom_range(20)) % TIME_WRAP,
                     $urandom_range(1), $urandom_range(31), $urandom_range(20'hFFFFF));
        else if (r < 95)
            send_cmd(CMD_TICK, $urandom_range(7), $urandom_range(1),
                     ($urandom_range(3) == 0) ? (cur_slot + $urandom_range(200)) % TIME_WRAP
                                              : cur_slot,
                     $urandom_range(1), $urandom_range(31), $urandom_range(20'hFFFFF));
        else
            send_cmd(cmd_t'($urandom_range(7)), $urandom_range(7), $urandom_range(1),
                     $urandom_range(16383), $urandom_range(1), $urandom_range(31),
                     $urandom_range(20'hFFFFF));
    endtask

    initial begin
        foreach (last_slot[i]) last_slot[i] = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        write_reg(REG_MAX_RETX, 2);
        write_reg(REG_ASYNC, 0);

        // directed: extremes, all commands, edge cases
        send_cmd(CMD_NEW_TX, 0, 0, 10, 0, 0, 0);
        send_cmd(CMD_NEW_TX, 7, 1, 10239, 1, 31, 20'hFFFFF);
        send_cmd(CMD_RETX, 3, 1, 20, 0, 0, 0);               // retx of inactive block
        send_cmd(CMD_ACK, 0, 0, 14, 1, 0, 0);                // ack of process 0
        send_cmd(CMD_ACK, 0, 1, 14, 0, 0, 0);                // inactive block matched
        send_cmd(CMD_ACK, 0, 0, 5000, 1, 0, 0);              // no match
        send_cmd(CMD_ACK, 0, 1, 3, 0, 0, 0);                 // wrapped slot, NACK
        send_cmd(CMD_RETX, 7, 1, 30, 0, 0, 0);
        send_cmd(CMD_ACK, 0, 1, 34, 0, 0, 0);                // NACK exhausting the limit
        send_cmd(CMD_NEW_TX, 2, 0, 40, 0, 9, 1234);
        send_cmd(CMD_RETX, 2, 0, 40, 0, 0, 0);
        send_cmd(CMD_FIND_PENDING, 0, 0, 42, 0, 0, 0);
        send_cmd(CMD_FIND_PENDING, 0, 0, 48, 0, 0, 0);
        send_cmd(CMD_FIND_EMPTY, 0, 0, 40, 0, 0, 0);
        send_cmd(CMD_FIND_EMPTY, 0, 0, 43, 0, 0, 0);
        send_cmd(CMD_TICK, 0, 0, 100, 0, 0, 0);
        send_cmd(CMD_TICK, 0, 0, 400, 0, 0, 0);              // stale drop
        send_cmd(CMD_NEW_TX, 5, 0, 16383, 1, 17, 77);        // slot out of range
        send_cmd(cmd_t'(6), 7, 1, 16383, 1, 31, 20'hFFFFF);
        send_cmd(cmd_t'(7), 0, 0, 0, 0, 0, 0);
        write_reg(REG_ASYNC, 1);
        send_cmd(CMD_NEW_TX, 1, 1, 500, 0, 3, 300);
        send_cmd(CMD_RETX, 1, 1, 502, 0, 0, 0);
        send_cmd(CMD_FIND_PENDING, 0, 0, 520, 0, 0, 0);
        send_cmd(CMD_FIND_EMPTY, 0, 0, 520, 0, 0, 0);
        write_reg(REG_MAX_RETX, 0);
        send_cmd(CMD_TICK, 0, 0, 520, 0, 0, 0);

        cur_slot = 600;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            case (ph)
                0: begin write_reg(REG_MAX_RETX, 4);  write_reg(REG_ASYNC, 0); end
                1: begin write_reg(REG_MAX_RETX, 15); write_reg(REG_ASYNC, 1); end
                2: begin write_reg(REG_MAX_RETX, 0);  write_reg(REG_ASYNC, 0); end
                3: begin write_reg(REG_MAX_RETX, 1);  write_reg(REG_ASYNC, 1); end
                4: begin write_reg(REG_MAX_RETX, 3);  write_reg(REG_ASYNC, 0); end
                5: begin write_reg(REG_MAX_RETX, 2);  write_reg(REG_ASYNC, 1); end
                6: begin write_reg(REG_MAX_RETX, 15); write_reg(REG_ASYNC, 0); end
                default: begin write_reg(REG_MAX_RETX, 4); write_reg(REG_ASYNC, 1); end
            endcase
            repeat (200) random_cmd();
        end

        s_tvalid = 1'b0;
        recv_stall_pct = 0;
        while (pending_count != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (err_count == 0 && pending_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
